[src/mkps_pkg.sv]
// Package for the matrix keypad scanner with key ring store.
// Holds item kind codes, the result struct and the key character table.
// No dependencies.
package mkps_pkg;

  localparam int ROW_COUNT    = 4;
  localparam int COLUMN_COUNT = 4;
  localparam int ROW_W        = 2;
  localparam int COL_W        = 2;
  localparam int CODE_W       = 8;
  localparam int MATCH_W      = 8;

  localparam logic [MATCH_W-1:0] DEBOUNCE_RESET = 8'd3;
  localparam logic [COLUMN_COUNT-1:0] NO_KEY_COLS = 4'hF;

  typedef enum logic [1:0] {
    KIND_SCAN        = 2'd0,
    KIND_READ_OLDEST = 2'd1,
    KIND_READ_NEWEST = 2'd2,
    KIND_CLEAR       = 2'd3
  } kind_t;

  typedef struct packed {
    logic                    key_valid;
    logic [CODE_W-1:0]       key_code;
    logic                    dropped_oldest;
    logic [ROW_COUNT-1:0]    row_drive;
    logic                    from_store;
  } res_t;

  function automatic logic [CODE_W-1:0] key_char(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    logic [CODE_W-1:0] ch;
    case ({row, col})
      4'h0: ch = "1";
      4'h1: ch = "2";
      4'h2: ch = "3";
      4'h3: ch = "A";
      4'h4: ch = "4";
      4'h5: ch = "5";
      4'h6: ch = "6";
      4'h7: ch = "B";
      4'h8: ch = "7";
      4'h9: ch = "8";
      4'hA: ch = "9";
      4'hB: ch = "C";
      4'hC: ch = "*";
      4'hD: ch = "0";
      4'hE: ch = "#";
      default: ch = "D";
    endcase
    return ch;
  endfunction

endpackage

[src/mkps_if.sv]
// Valid/ready channel interfaces for keypad scanner items and results.
// Depends on nothing; widths follow the package constants by value.
interface mkps_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] column_sense;

  modport source (output valid, output kind, output column_sense, input ready);
  modport sink   (input valid, input kind, input column_sense, output ready);
endinterface

interface mkps_result_if #(
  parameter int COUNT_W = 5
);
  logic               valid;
  logic               ready;
  logic               key_valid;
  logic [7:0]         key_code;
  logic               dropped_oldest;
  logic [COUNT_W-1:0] key_count;
  logic [3:0]         row_drive;

  modport source (output valid, output key_valid, output key_code, output dropped_oldest,
                  output key_count, output row_drive, input ready);
  modport sink   (input valid, input key_valid, input key_code, input dropped_oldest,
                  input key_count, input row_drive, output ready);
endinterface

[src/mkps_ctrl.sv]
// Scan, debounce and ring pointer control for the keypad scanner.
// Issues key store reads/writes; uses mkps_pkg.
module mkps_ctrl #(
  parameter int STORE_DEPTH = 16,
  parameter int PTR_W       = 4,
  parameter int COUNT_W     = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  accept,
  input  logic [1:0]            kind,
  input  logic [3:0]            column_sense,
  output mkps_pkg::res_t        res,
  output logic [COUNT_W-1:0]    count_out,
  output logic                  mem_we,
  output logic [PTR_W-1:0]      mem_waddr,
  output logic [7:0]            mem_wdata,
  output logic                  mem_re,
  output logic [PTR_W-1:0]      mem_raddr
);
  import mkps_pkg::*;

  localparam int SUM_W = COUNT_W + 1;
  localparam logic [SUM_W-1:0]   DEPTH_S = SUM_W'(STORE_DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(STORE_DEPTH);
  localparam logic [PTR_W-1:0]   LAST_P  = PTR_W'(STORE_DEPTH - 1);

  logic [MATCH_W-1:0]      debounce_matches;
  logic [ROW_W-1:0]        active_row, active_row_next;
  logic [COLUMN_COUNT-1:0] previous_columns, previous_columns_next;
  logic [MATCH_W-1:0]      match_counter, match_counter_next;
  logic [PTR_W-1:0]        read_pointer, read_pointer_next;
  logic [COUNT_W-1:0]      stored_count, stored_count_next;

  logic [SUM_W-1:0]   sum_tail;
  logic [SUM_W-1:0]   sum_newest;
  logic [PTR_W-1:0]   ptr_inc;
  logic [MATCH_W-1:0] match_inc;
  logic [COL_W-1:0]   low_col;
  logic [CODE_W-1:0]  scan_char;

  function automatic logic [PTR_W-1:0] wrap_sum(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return PTR_W'(r);
  endfunction

  assign sum_tail   = SUM_W'(read_pointer) + SUM_W'(stored_count);
  assign sum_newest = sum_tail - SUM_W'(1);
  assign ptr_inc    = (read_pointer == LAST_P) ? '0 : read_pointer + PTR_W'(1);
  assign match_inc  = match_counter + MATCH_W'(1);

  always_comb begin
    if (!column_sense[0]) begin
      low_col = 2'd0;
    end else if (!column_sense[1]) begin
      low_col = 2'd1;
    end else if (!column_sense[2]) begin
      low_col = 2'd2;
    end else begin
      low_col = 2'd3;
    end
  end

  assign scan_char = key_char(active_row, low_col);

  always_comb begin
    active_row_next       = active_row;
    previous_columns_next = previous_columns;
    match_counter_next    = match_counter;
    read_pointer_next     = read_pointer;
    stored_count_next     = stored_count;
    res.key_valid         = 1'b0;
    res.key_code          = '0;
    res.dropped_oldest    = 1'b0;
    res.from_store        = 1'b0;
    mem_we                = 1'b0;
    mem_waddr             = wrap_sum(sum_tail);
    mem_wdata             = scan_char;
    mem_re                = 1'b0;
    mem_raddr             = read_pointer;
    case (kind_t'(kind))
      KIND_SCAN: begin
        if (column_sense == NO_KEY_COLS) begin
          active_row_next       = active_row + ROW_W'(1);
          previous_columns_next = NO_KEY_COLS;
          match_counter_next    = '0;
        end else if (column_sense != previous_columns) begin
          previous_columns_next = column_sense;
          match_counter_next    = '0;
        end else if (match_counter < debounce_matches) begin
          match_counter_next = match_inc;
          if (match_inc == debounce_matches) begin
            res.key_valid = 1'b1;
            res.key_code  = scan_char;
            mem_we        = accept;
            if (stored_count < DEPTH_C) begin
              stored_count_next = stored_count + COUNT_W'(1);
            end else begin
              mem_waddr          = read_pointer;
              read_pointer_next  = ptr_inc;
              res.dropped_oldest = 1'b1;
            end
          end
        end
      end
      KIND_READ_OLDEST: begin
        if (stored_count != '0) begin
          res.key_valid     = 1'b1;
          res.from_store    = 1'b1;
          mem_re            = accept;
          read_pointer_next = ptr_inc;
          stored_count_next = stored_count - COUNT_W'(1);
        end
      end
      KIND_READ_NEWEST: begin
        if (stored_count != '0) begin
          res.key_valid     = 1'b1;
          res.from_store    = 1'b1;
          mem_re            = accept;
          mem_raddr         = wrap_sum(sum_newest);
          stored_count_next = '0;
        end
      end
      default: begin
        stored_count_next = '0;
      end
    endcase
  end

  assign res.row_drive = ~(ROW_COUNT'(1) << active_row_next);
  assign count_out     = stored_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_matches <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_matches <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_row       <= '0;
      previous_columns <= '0;
      match_counter    <= '0;
      read_pointer     <= '0;
      stored_count     <= '0;
    end else if (accept) begin
      active_row       <= active_row_next;
      previous_columns <= previous_columns_next;
      match_counter    <= match_counter_next;
      read_pointer     <= read_pointer_next;
      stored_count     <= stored_count_next;
    end
  end

endmodule

[src/mkps_store.sv]
// Key ring store: one write port, one read port, registered read data.
// No package dependencies.
module mkps_store #(
  parameter int STORE_DEPTH = 16,
  parameter int PTR_W       = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [PTR_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [PTR_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/mkps_outq.sv]
// Result pipeline: store-read stage then output register.
// Merges store read data into the result; uses mkps_pkg and mkps_result_if.
module mkps_outq #(
  parameter int COUNT_W = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  output logic                 item_ready,
  input  mkps_pkg::res_t       res,
  input  logic [COUNT_W-1:0]   count_in,
  input  logic [7:0]           rdata,
  mkps_result_if.source        result
);
  import mkps_pkg::*;

  logic               s1_valid;
  res_t               s1_res;
  logic [COUNT_W-1:0] s1_count;
  logic               s1_adv;

  assign s1_adv     = s1_valid && (!result.valid || result.ready);
  assign item_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res   <= res;
      s1_count <= count_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.key_valid      <= s1_res.key_valid;
      result.key_code       <= s1_res.from_store ? rdata : s1_res.key_code;
      result.dropped_oldest <= s1_res.dropped_oldest;
      result.key_count      <= s1_count;
      result.row_drive      <= s1_res.row_drive;
    end
  end

endmodule

[src/matrix_keypad_scanner_fifo_top.sv]
// Channel     Dir  Handshake      Payload
// item        in   valid/ready    kind, column_sense
// result      out  valid/ready    key_valid, key_code, dropped_oldest, key_count, row_drive
// cfg         in   cfg_we         cfg_wdata (debounce_matches)
//
// One transaction per cycle while the result is not stalled; each result is registered
// first alongside the key store's registered read data, then in the output register.
// Synchronous reset clears control state; store contents are not cleared.
// A stalled result holds the pipeline; item ready drops once both stages are full.
// Top level of the keypad scanner; depends on mkps_pkg, mkps_if, mkps_ctrl,
// mkps_store and mkps_outq.
module matrix_keypad_scanner_fifo_top #(
  parameter int STORE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  mkps_item_if.sink     item,
  mkps_result_if.source result
);
  import mkps_pkg::*;

  localparam int PTR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(STORE_DEPTH + 1);

  logic               accept;
  res_t               res;
  logic [COUNT_W-1:0] count;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [PTR_W-1:0]   mem_raddr;
  logic [7:0]         mem_rdata;

  assign accept = item.valid && item.ready;

  mkps_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .PTR_W       (PTR_W),
    .COUNT_W     (COUNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .kind         (item.kind),
    .column_sense (item.column_sense),
    .res          (res),
    .count_out    (count),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr)
  );

  mkps_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .PTR_W       (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mkps_outq #(
    .COUNT_W (COUNT_W)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item_ready (item.ready),
    .res        (res),
    .count_in   (count),
    .rdata      (mem_rdata),
    .result     (result)
  );

endmodule

[src/mkps_checker.sv]
// Port-level checks for the keypad scanner result channel, bound to the top.
// Depends on matrix_keypad_scanner_fifo_top port and parameter names only.
module mkps_port_checks #(
  parameter int STORE_DEPTH = 16,
  parameter int COUNT_W     = 5
) (
  input logic               clk,
  input logic               rst,
  input logic               valid,
  input logic               ready,
  input logic               key_valid,
  input logic [7:0]         key_code,
  input logic               dropped_oldest,
  input logic [COUNT_W-1:0] key_count,
  input logic [3:0]         row_drive
);

  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(STORE_DEPTH);

  a_row_onehot: assert property (@(posedge clk) disable iff (rst)
    valid |-> $onehot(~row_drive))
    else $error("row_drive does not drive exactly one row low");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> key_count <= DEPTH_C)
    else $error("key_count above store depth");

  a_code_idle: assert property (@(posedge clk) disable iff (rst)
    (valid && !key_valid) |-> key_code == 8'd0)
    else $error("key_code nonzero without key_valid");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (valid && dropped_oldest) |-> (key_valid && key_count == DEPTH_C))
    else $error("dropped_oldest without a push into a full store");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> (valid && $stable(key_code) && $stable(key_count)))
    else $error("stalled result transaction changed");

endmodule

bind matrix_keypad_scanner_fifo_top mkps_port_checks #(
  .STORE_DEPTH (STORE_DEPTH),
  .COUNT_W     ($clog2(STORE_DEPTH + 1))
) u_mkps_port_checks (
  .clk            (clk),
  .rst            (rst),
  .valid          (result.valid),
  .ready          (result.ready),
  .key_valid      (result.key_valid),
  .key_code       (result.key_code),
  .dropped_oldest (result.dropped_oldest),
  .key_count      (result.key_count),
  .row_drive      (result.row_drive)
);
